>>> sv/pcr_pkg.sv
// Shared types, key color ROM and helper functions of the piecewise color ramp.
// No dependencies; every file but pcr_fifo imports this package.
`timescale 1ns / 1ps
package pcr_pkg;

  // Largest table the ramp serves; writes above it saturate
  localparam logic [12:0] MAX_COLORS = 13'd4096;

  // Default queue depths: mid queue between front and back, and result queue
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF   = 16;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SCALE_SELECT = 1'b0,
    CFG_TABLE_SIZE   = 1'b1
  } cfg_idx_e;

  // Item classes decided by the front
  typedef enum logic [1:0] {
    CLS_OUT   = 2'd0,
    CLS_FIRST = 2'd1,
    CLS_LAST  = 2'd2,
    CLS_MID   = 2'd3
  } cls_e;

  // Key colors, one row per scale, unused keys zero
  localparam logic [7:0] KEY_R [0:7][0:7] = '{
    '{8'd40,  8'd127, 8'd230, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0},
    '{8'd30,  8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd255, 8'd30,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd40,  8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd0,   8'd0,   8'd0,   8'd153, 8'd255, 8'd255, 8'd255, 8'd0},
    '{8'd30,  8'd200, 8'd230, 8'd30,  8'd255, 8'd0,   8'd0,   8'd0},
    '{8'd30,  8'd30,  8'd30,  8'd230, 8'd245, 8'd255, 8'd0,   8'd0},
    '{8'd100, 8'd235, 8'd0,   8'd130, 8'd0,   8'd0,   8'd0,   8'd0}
  };
  localparam logic [7:0] KEY_G [0:7][0:7] = '{
    '{8'd20,  8'd0,   8'd127, 8'd180, 8'd255, 8'd0,   8'd0,   8'd0},
    '{8'd30,  8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd255, 8'd30,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd80,  8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd153, 8'd0,   8'd0},
    '{8'd30,  8'd30,  8'd230, 8'd30,  8'd255, 8'd0,   8'd0,   8'd0},
    '{8'd30,  8'd30,  8'd200, 8'd30,  8'd245, 8'd255, 8'd0,   8'd0},
    '{8'd0,   8'd255, 8'd235, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0}
  };
  localparam logic [7:0] KEY_B [0:7][0:7] = '{
    '{8'd20,  8'd0,   8'd0,   8'd77,  8'd255, 8'd0,   8'd0,   8'd0},
    '{8'd30,  8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd255, 8'd30,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd77,  8'd204, 8'd255, 8'd77,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd30,  8'd30,  8'd30,  8'd255, 8'd255, 8'd0,   8'd0,   8'd0},
    '{8'd30,  8'd200, 8'd30,  8'd30,  8'd30,  8'd255, 8'd0,   8'd0},
    '{8'd0,   8'd0,   8'd255, 8'd130, 8'd0,   8'd0,   8'd0,   8'd0}
  };
  // Index of the last key of each scale
  localparam logic [2:0] KEY_LAST [0:7] = '{
    3'd4, 3'd1, 3'd1, 3'd1, 3'd6, 3'd4, 3'd5, 3'd3
  };

  // Item handed from the front to the back
  typedef struct packed {
    cls_e        cls;
    logic [11:0] last;    // table_size - 1
    logic [14:0] prod;    // index * last key
    logic [2:0]  scale;
    logic [2:0]  k;
    logic [23:0] direct;  // key color for end entries
  } pcr_item_t;

  // Result as queued for the output side
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       index_valid;
  } pcr_res_t;

  function automatic logic [23:0] key_rgb(input logic [2:0] s, input logic [2:0] i);
    return {KEY_R[s][i], KEY_G[s][i], KEY_B[s][i]};
  endfunction

  function automatic logic [2:0] key_last(input logic [2:0] s);
    return KEY_LAST[s];
  endfunction

endpackage

>>> sv/pcr_fifo.sv
// Small synchronous queue with push/full and pop/empty sides.
// Standalone; used for the mid queue and the result queue.
`timescale 1ns / 1ps
module pcr_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem[rd_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

endmodule

>>> sv/pcr_front.sv
// Front of the color ramp: classifies an index and forms index * last key.
// Depends on pcr_pkg.
`timescale 1ns / 1ps
module pcr_front (
  input  logic [11:0]         color_index_i,
  input  logic [2:0]          scale_i,
  input  logic [12:0]         table_size_i,
  output pcr_pkg::pcr_item_t  item_o
);
  import pcr_pkg::*;

  logic [2:0]  k;
  logic [12:0] idx_ext;
  cls_e        cls;

  assign k       = key_last(scale_i);
  assign idx_ext = {1'b0, color_index_i};

  // Classify against the table bounds
  always_comb begin
    if (idx_ext >= table_size_i) begin
      cls = CLS_OUT;
    end else if (idx_ext == table_size_i - 13'd1) begin
      cls = CLS_LAST;
    end else if (color_index_i == 12'd0) begin
      cls = CLS_FIRST;
    end else begin
      cls = CLS_MID;
    end
  end

  // Build the item for the back
  always_comb begin
    item_o.cls    = cls;
    item_o.last   = table_size_i[11:0] - 12'd1;
    item_o.prod   = 15'(color_index_i) * 15'(k);
    item_o.scale  = scale_i;
    item_o.k      = k;
    item_o.direct = (cls == CLS_LAST) ? key_rgb(scale_i, k) : key_rgb(scale_i, 3'd0);
  end

endmodule

>>> sv/pcr_back.sv
// Back of the color ramp: pipelined segment divide, key lookup, blend and
// per-channel divide by table_size-1. Issues only against result queue credit.
// Depends on pcr_pkg.
`timescale 1ns / 1ps
module pcr_back #(
  parameter int unsigned OUT_DEPTH = pcr_pkg::OUT_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcr_pkg::pcr_item_t item_i,
  input  logic               item_avail_i,
  output logic               item_pop_o,
  output logic               res_push_o,
  output pcr_pkg::pcr_res_t  res_o,
  input  logic               res_pop_i
);
  import pcr_pkg::*;

  localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    cls_e        cls;
    logic [11:0] last;
    logic [14:0] rem;
    logic [2:0]  quo;
    logic [2:0]  scale;
    logic [2:0]  k;
    logic [23:0] direct;
  } seg_t;

  typedef struct packed {
    cls_e        cls;
    logic [11:0] last;
    logic [11:0] w0;
    logic [11:0] rem;
    logic [23:0] a;
    logic [23:0] b;
    logic [23:0] direct;
  } mix_t;

  typedef struct packed {
    cls_e        cls;
    logic [11:0] last;
    logic [23:0] direct;
    logic [2:0][19:0] num;
    logic [2:0][7:0]  quo;
  } div_t;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          issue;

  seg_t seg_in;
  seg_t seg_q [3];
  logic seg_v_q [3];
  seg_t seg_nx [3];

  mix_t mix_d, mix_q;
  logic mix_v_q;

  div_t div_d [9];
  div_t div_q [9];
  logic div_v_q [9];

  // Take an item only while the result queue has room for it
  assign issue      = item_avail_i && (cnt_q < CW'(OUT_DEPTH));
  assign item_pop_o = issue;

  always_comb begin
    cnt_d = cnt_q;
    if (issue && !res_pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!issue && res_pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_comb begin
    seg_in.cls    = item_i.cls;
    seg_in.last   = item_i.last;
    seg_in.rem    = item_i.prod;
    seg_in.quo    = 3'd0;
    seg_in.scale  = item_i.scale;
    seg_in.k      = item_i.k;
    seg_in.direct = item_i.direct;
  end

  // Segment divide: one quotient bit per stage, MSB first
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      seg_t src;
      logic [14:0] dv;
      src = (j == 0) ? seg_in : seg_q[j-1];
      dv  = {3'b000, src.last} << (2 - j);
      seg_nx[j] = src;
      if (src.rem >= dv) begin
        seg_nx[j].rem      = src.rem - dv;
        seg_nx[j].quo[2-j] = 1'b1;
      end
    end
  end

  // Look up the two bounding key colors
  always_comb begin
    logic [2:0] base, nxt;
    base = (seg_q[2].quo >= seg_q[2].k) ? seg_q[2].k : seg_q[2].quo;
    nxt  = (base < seg_q[2].k) ? base + 3'd1 : base;
    mix_d.cls    = seg_q[2].cls;
    mix_d.last   = seg_q[2].last;
    mix_d.rem    = seg_q[2].rem[11:0];
    mix_d.w0     = seg_q[2].last - seg_q[2].rem[11:0];
    mix_d.a      = key_rgb(seg_q[2].scale, base);
    mix_d.b      = key_rgb(seg_q[2].scale, nxt);
    mix_d.direct = seg_q[2].direct;
  end

  // Blend numerators, then channel divide one quotient bit per stage
  always_comb begin
    div_d[0].cls    = mix_q.cls;
    div_d[0].last   = mix_q.last;
    div_d[0].direct = mix_q.direct;
    div_d[0].quo    = '0;
    for (int c = 0; c < 3; c++) begin
      div_d[0].num[c] = 20'(mix_q.w0) * 20'(mix_q.a[8*c +: 8]) +
                        20'(mix_q.rem) * 20'(mix_q.b[8*c +: 8]);
    end
    for (int j = 1; j < 9; j++) begin
      logic [19:0] dv;
      dv       = {8'd0, div_q[j-1].last} << (8 - j);
      div_d[j] = div_q[j-1];
      for (int c = 0; c < 3; c++) begin
        if (div_q[j-1].num[c] >= dv) begin
          div_d[j].num[c]      = div_q[j-1].num[c] - dv;
          div_d[j].quo[c][8-j] = 1'b1;
        end
      end
    end
  end

  // Pick the result by class
  always_comb begin
    res_push_o = div_v_q[8];
    case (div_q[8].cls)
      CLS_OUT: begin
        res_o = '0;
      end
      CLS_FIRST, CLS_LAST: begin
        res_o = {div_q[8].direct, 1'b1};
      end
      CLS_MID: begin
        res_o = {div_q[8].quo[2], div_q[8].quo[1], div_q[8].quo[0], 1'b1};
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

  // Valid line and credit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      mix_v_q <= 1'b0;
      for (int j = 0; j < 3; j++) seg_v_q[j] <= 1'b0;
      for (int j = 0; j < 9; j++) div_v_q[j] <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      seg_v_q[0] <= issue;
      seg_v_q[1] <= seg_v_q[0];
      seg_v_q[2] <= seg_v_q[1];
      mix_v_q    <= seg_v_q[2];
      div_v_q[0] <= mix_v_q;
      for (int j = 1; j < 9; j++) div_v_q[j] <= div_v_q[j-1];
    end
  end

  // Payload advances every cycle
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) seg_q[j] <= seg_nx[j];
    mix_q <= mix_d;
    for (int j = 0; j < 9; j++) div_q[j] <= div_d[j];
  end

endmodule

>>> sv/piecewise_color_ramp_unit.sv
// Piecewise linear color ramp: one item per cycle while the result queue holds
// a free slot. Stages around the pipelined restoring divider by table_size-1:
// three stages find the key segment, one looks up
// the keys, one blends, eight resolve the 8-bit channel quotients. An item
// issues from the mid queue only while the result queue holds a free slot,
// so OUT_DEPTH must be at least 15 for a sustained rate of one per cycle.
// Configuration takes effect for items pushed after the write.
// Depends on pcr_pkg, pcr_fifo, pcr_front, pcr_back.
`timescale 1ns / 1ps
module piecewise_color_ramp_unit #(
  parameter int unsigned QUEUE_DEPTH = pcr_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH   = pcr_pkg::OUT_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [11:0] color_index_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        index_valid_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  import pcr_pkg::*;

  logic [2:0]  scale_q;
  logic [12:0] table_size_q;
  pcr_item_t   front_item, mid_item;
  logic        mid_empty, mid_pop;
  logic        res_push, res_full;
  pcr_res_t    res_in, res_out;

  assign cfg_ready_o = 1'b1;

  // Configuration registers, table size saturates at the maximum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q      <= 3'd0;
      table_size_q <= 13'd256;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SCALE_SELECT: begin
          scale_q <= cfg_data_i[2:0];
        end
        CFG_TABLE_SIZE: begin
          table_size_q <= (cfg_data_i > MAX_COLORS) ? MAX_COLORS : cfg_data_i;
        end
        default: begin
          scale_q <= scale_q;
        end
      endcase
    end
  end

  pcr_front u_front (
    .color_index_i (color_index_i),
    .scale_i       (scale_q),
    .table_size_i  (table_size_q),
    .item_o        (front_item)
  );

  pcr_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(pcr_item_t))) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (mid_item),
    .empty_o (mid_empty)
  );

  pcr_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (mid_item),
    .item_avail_i (~mid_empty),
    .item_pop_o   (mid_pop),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .res_pop_i    (pop & ~empty)
  );

  pcr_fifo #(.DEPTH(OUT_DEPTH), .WIDTH($bits(pcr_res_t))) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign red_o         = res_out.red;
  assign green_o       = res_out.green;
  assign blue_o        = res_out.blue;
  assign index_valid_o = res_out.index_valid;

  // Credit scheme must never overrun the result queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result queue overrun");

  // Out-of-range results carry zero color
  a_zero_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !index_valid_o) |-> (red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0))
    else $error("invalid index with nonzero color");

  // Table size register stays within range
  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    table_size_q <= MAX_COLORS)
    else $error("table size above maximum");

endmodule
